// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every edge outside reset.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/lbcg_pkg.sv -----
// ----------------------------------------------------------------------------
// lbcg_pkg
// Types, mode codes and register defaults of the LED blink code generator.
// ----------------------------------------------------------------------------
package lbcg_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned CountW = 7;
  localparam int unsigned MsW    = 16;
  localparam int unsigned CfgIdxW = 3;

  // Request modes
  localparam logic [OpW-1:0] MODE_CODE = 3'd0;
  localparam logic [OpW-1:0] MODE_ON   = 3'd1;
  localparam logic [OpW-1:0] MODE_OFF  = 3'd2;
  localparam logic [OpW-1:0] MODE_SLOW = 3'd3;
  localparam logic [OpW-1:0] MODE_FAST = 3'd4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_INVERT   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ON_SPAN  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_OFF_SPAN = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_COOLDOWN = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SLOW     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FAST     = 3'd5;

  // Reset values
  localparam logic [MsW-1:0] ON_SPAN_RST  = 16'd80;
  localparam logic [MsW-1:0] OFF_SPAN_RST = 16'd150;
  localparam logic [MsW-1:0] COOLDOWN_RST = 16'd1000;
  localparam logic [MsW-1:0] SLOW_RST     = 16'd500;
  localparam logic [MsW-1:0] FAST_RST     = 16'd150;

  typedef struct packed {
    logic           invert;
    logic [MsW-1:0] on_span;
    logic [MsW-1:0] off_span;
    logic [MsW-1:0] cooldown;
    logic [MsW-1:0] slow_period;
    logic [MsW-1:0] fast_period;
  } cfg_t;

  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [CountW-1:0] blink_count;
    logic [MsW-1:0]    elapsed_ms;
  } tick_t;

endpackage

// ----- hw/rtl/lbcg_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lbcg_cfg_regs
// Configuration register file, write only. Unknown indexes are dropped.
// ----------------------------------------------------------------------------
module lbcg_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lbcg_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [lbcg_pkg::MsW-1:0]        cfg_wdata,
  output lbcg_pkg::cfg_t                  cfg
);

  lbcg_pkg::cfg_t cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert      <= 1'b0;
      cfg_r.on_span     <= lbcg_pkg::ON_SPAN_RST;
      cfg_r.off_span    <= lbcg_pkg::OFF_SPAN_RST;
      cfg_r.cooldown    <= lbcg_pkg::COOLDOWN_RST;
      cfg_r.slow_period <= lbcg_pkg::SLOW_RST;
      cfg_r.fast_period <= lbcg_pkg::FAST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbcg_pkg::REG_INVERT:   cfg_r.invert      <= cfg_wdata[0];
        lbcg_pkg::REG_ON_SPAN:  cfg_r.on_span     <= cfg_wdata;
        lbcg_pkg::REG_OFF_SPAN: cfg_r.off_span    <= cfg_wdata;
        lbcg_pkg::REG_COOLDOWN: cfg_r.cooldown    <= cfg_wdata;
        lbcg_pkg::REG_SLOW:     cfg_r.slow_period <= cfg_wdata;
        lbcg_pkg::REG_FAST:     cfg_r.fast_period <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/lbcg_tick_engine.sv -----
// ----------------------------------------------------------------------------
// lbcg_tick_engine
// Timer, request tracking, pulse counter and LED flag; one tick per strobe.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbcg_tick_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tick_fire,
  input  lbcg_pkg::tick_t tick,
  input  lbcg_pkg::cfg_t  cfg,
  output logic            lit_nxt
);

  logic [lbcg_pkg::MsW-1:0]    timer_r, timer_nxt;
  logic                        prev_valid_r;
  logic [lbcg_pkg::OpW-1:0]    prev_mode_r;
  logic [lbcg_pkg::CountW-1:0] prev_count_r;
  logic [lbcg_pkg::CountW-1:0] pulse_cnt_r, pulse_cnt_nxt;
  logic                        lit_r;

  logic [lbcg_pkg::OpW-1:0]    mode;
  logic [lbcg_pkg::CountW-1:0] count;
  logic [lbcg_pkg::MsW-1:0]    timer_sum;
  logic [lbcg_pkg::MsW-1:0]    period;
  logic [lbcg_pkg::MsW:0]      restart_lim;
  logic [lbcg_pkg::CountW-1:0] pc_code;
  logic                        change;

  // Request normalization
  always_comb begin
    mode = tick.opcode;
    if (tick.opcode > lbcg_pkg::MODE_FAST) mode = lbcg_pkg::MODE_OFF;
    if (tick.opcode == lbcg_pkg::MODE_CODE && tick.blink_count == '0)
      mode = lbcg_pkg::MODE_SLOW;
    count = (mode == lbcg_pkg::MODE_CODE) ? tick.blink_count : '0;
  end

  assign timer_sum   = timer_r + tick.elapsed_ms;
  assign change      = !prev_valid_r || (mode != prev_mode_r) || (count != prev_count_r);
  assign period      = (mode == lbcg_pkg::MODE_SLOW) ? cfg.slow_period : cfg.fast_period;
  assign restart_lim = {1'b0, cfg.cooldown} + {1'b0, cfg.off_span};
  // Code restart after cooldown
  assign pc_code     = ({1'b0, timer_sum} > restart_lim && pulse_cnt_r >= count) ?
                       '0 : pulse_cnt_r;

  // Per-tick update
  always_comb begin
    timer_nxt     = timer_sum;
    pulse_cnt_nxt = pulse_cnt_r;
    lit_nxt       = lit_r;
    if (change) begin
      timer_nxt     = '0;
      pulse_cnt_nxt = '0;
      lit_nxt       = 1'b0;
    end else begin
      case (mode)
        lbcg_pkg::MODE_ON, lbcg_pkg::MODE_OFF: begin
          lit_nxt       = (mode == lbcg_pkg::MODE_ON);
          timer_nxt     = '0;
          pulse_cnt_nxt = '0;
        end
        lbcg_pkg::MODE_SLOW, lbcg_pkg::MODE_FAST: begin
          if (timer_sum >= period) begin
            timer_nxt     = '0;
            pulse_cnt_nxt = '0;
            lit_nxt       = !lit_r;
          end
        end
        default: begin
          pulse_cnt_nxt = pc_code;
          if (!lit_r && timer_sum > cfg.off_span && pc_code < count) begin
            lit_nxt   = 1'b1;
            timer_nxt = '0;
          end else if (lit_r && timer_sum > cfg.on_span && pc_code < count) begin
            lit_nxt       = 1'b0;
            timer_nxt     = '0;
            pulse_cnt_nxt = pc_code + 1'b1;
          end
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r      <= '0;
      prev_valid_r <= 1'b0;
      prev_mode_r  <= lbcg_pkg::MODE_CODE;
      prev_count_r <= '0;
      pulse_cnt_r  <= '0;
      lit_r        <= 1'b0;
    end else if (tick_fire) begin
      timer_r      <= timer_nxt;
      prev_valid_r <= 1'b1;
      prev_mode_r  <= mode;
      prev_count_r <= count;
      pulse_cnt_r  <= pulse_cnt_nxt;
      lit_r        <= lit_nxt;
    end
  end

  `ASSERT_CLK_RST(a_change_dark, clk, rst_n, tick_fire && change |=> !lit_r, "lit after request change")
  `ASSERT_CLK_RST(a_pulse_bound, clk, rst_n, prev_valid_r |-> pulse_cnt_r <= prev_count_r, "pulse counter past count")
  `ASSERT_CLK_RST(a_const_timer, clk, rst_n, prev_valid_r && (prev_mode_r == lbcg_pkg::MODE_ON || prev_mode_r == lbcg_pkg::MODE_OFF) |-> timer_r == '0, "timer running in constant mode")

endmodule

// ----- hw/rtl/led_blink_code_generator_unit.sv -----
// ----------------------------------------------------------------------------
// led_blink_code_generator_unit
// LED blink code generator: one tick in, one LED state out.
// ----------------------------------------------------------------------------
// Each input transfer is one tick carrying the elapsed milliseconds and the
// requested mode; each tick yields exactly one result transfer with the LED
// state and the pin level. Throughput is one tick per clock: a tick is
// captured in the input register, evaluated against the timer and pulse
// state, and lands in the output register. Backpressure on out_ready stalls
// the two-stage pipe in place. Configuration is written through cfg_we,
// cfg_index and cfg_wdata, only while idle: a user rule, not enforced.
`include "assert_macros.svh"

module led_blink_code_generator_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lbcg_pkg::OpW-1:0]         in_opcode,
  input  logic [lbcg_pkg::CountW-1:0]      in_blink_count,
  input  logic [lbcg_pkg::MsW-1:0]         in_elapsed_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_led_lit,
  output logic                             out_pin_level,
  input  logic                             cfg_we,
  input  logic [lbcg_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [lbcg_pkg::MsW-1:0]         cfg_wdata
);

  lbcg_pkg::cfg_t  cfg;
  lbcg_pkg::tick_t s1_tick_r;
  logic            s1_valid_r;
  logic            out_valid_r;
  logic            lit_r, pin_r;
  logic            lit_nxt;
  logic            adv;

  lbcg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Stage advance: output slot free or being drained
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;

  lbcg_tick_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_fire (s1_valid_r && adv),
    .tick      (s1_tick_r),
    .cfg       (cfg),
    .lit_nxt   (lit_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_tick_r.opcode      <= in_opcode;
      s1_tick_r.blink_count <= in_blink_count;
      s1_tick_r.elapsed_ms  <= in_elapsed_ms;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      lit_r <= lit_nxt;
      pin_r <= lit_nxt ^ cfg.invert;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_led_lit   = lit_r;
  assign out_pin_level = pin_r;

  `ASSERT_CLK(a_stall_full, clk, !in_ready |-> s1_valid_r && out_valid_r, "input stalled with room")
  `ASSERT_CLK_RST(a_no_drop, clk, rst_n, s1_valid_r && !adv |=> s1_valid_r, "queued tick dropped")

endmodule
